### hw/rtl/uuidp_pkg.sv
// Package for the UUID text parser: character codes, positions and the decode struct.
package uuidp_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned PosW     = 6;
  localparam int unsigned WordW    = 32;
  localparam int unsigned NumWords = 4;
  localparam int unsigned NibW     = 4;

  localparam logic [PosW-1:0] UuidLen  = PosW'(36);
  localparam logic [PosW-1:0] DashPos0 = PosW'(8);
  localparam logic [PosW-1:0] DashPos1 = PosW'(13);
  localparam logic [PosW-1:0] DashPos2 = PosW'(18);
  localparam logic [PosW-1:0] DashPos3 = PosW'(23);
  // Start of the position range assigned to each of words 1, 2 and 3.
  localparam logic [PosW-1:0] Word1Start = PosW'(8);
  localparam logic [PosW-1:0] Word2Start = PosW'(19);
  localparam logic [PosW-1:0] Word3Start = PosW'(28);

  localparam logic [CharW-1:0] ChDash  = 8'h2D;
  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowF  = 8'h66;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpF   = 8'h46;

  localparam int unsigned     ApbAddrW   = 3;
  localparam int unsigned     ApbDataW   = 32;
  localparam logic            RegReqTerm = 1'b0;  // register index held in paddr[2]

  typedef struct packed {
    logic              is_hex;
    logic              is_dash;
    logic              is_nul;
    logic [NibW-1:0]   nibble;
  } char_dec_t;

endpackage

### hw/rtl/uuidp_char_dec.sv
// Character classifier for the UUID text parser: hex digit value, dash and NUL flags.
module uuidp_char_dec
  import uuidp_pkg::*;
(
  input  logic [CharW-1:0] ch_i,
  output char_dec_t        dec_o
);

  logic is_digit, is_lower, is_upper;
  logic [CharW-1:0] offset;

  always_comb begin
    is_digit = (ch_i >= ChZero) && (ch_i <= ChNine);
    is_lower = (ch_i >= ChLowA) && (ch_i <= ChLowF);
    is_upper = (ch_i >= ChUpA) && (ch_i <= ChUpF);
    if (is_digit) begin
      offset = ch_i - ChZero;
    end else if (is_lower) begin
      offset = ch_i - ChLowA + CharW'(10);
    end else begin
      offset = ch_i - ChUpA + CharW'(10);
    end
    dec_o.is_hex  = is_digit | is_lower | is_upper;
    dec_o.is_dash = (ch_i == ChDash);
    dec_o.is_nul  = (ch_i == ChNul);
    dec_o.nibble  = offset[NibW-1:0];
  end

endmodule

### hw/rtl/uuid_text_parser.sv
// Top level of the UUID text parser: stream in, one result per decided string out, APB register.
//
// The block reads a text string one character per request on the slave stream
// (tdata = the character byte, tuser = start flag marking the first character)
// and parses the 36-character form xxxxxxxx-xxxx-xxxx-xxxx-xxxxxxxxxxxx.
// Each decided string gives exactly one result on the master stream: tdata carries the
// four 32-bit words, tuser carries the ok flag. A failure is reported at the
// first bad character with all words zero; characters after the decision are
// dropped until the next start flag. A start flag while a string is in flight
// abandons that string without a result.
//
// One APB register, require_terminator at address 0 (reset 1): when set, a NUL
// must follow the 36 characters; when clear, success is reported with the last
// digit. Write it only while no string is in progress.
//
// Throughput is one character per cycle while the output is not stalled: each
// accepted request updates the position counter and, for a digit, shifts one
// nibble into the word store. The result is registered at the edge that takes
// the deciding character and is offered from the next cycle on. While a result
// waits and the receiver stalls, tready is low for every character, deciding or
// not (tready = output register empty or being drained). Reset clears the position,
// the words, the in-progress flag and the output valid, and sets require_terminator.
module uuid_text_parser
  import uuidp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Slave stream
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [CharW-1:0]         s_axis_tdata_i,   // [7:0] ch
  input  logic                     s_axis_tuser_i,   // [0] start_req
  // Master stream
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [NumWords*WordW-1:0] m_axis_tdata_o,  // [31:0] word0, [63:32] word1,
                                                     // [95:64] word2, [127:96] word3
  output logic                     m_axis_tuser_o,   // [0] ok
  // APB configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ApbAddrW-1:0]      paddr,
  input  logic [ApbDataW-1:0]      pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready
);

  // Configuration register.
  logic req_term_q;

  // Parser state.
  logic                         busy_q, busy_d;
  logic [PosW-1:0]              pos_q, pos_d;
  logic [NumWords-1:0][WordW-1:0] words_q, words_d;

  // Output register.
  logic                         out_valid_q;
  logic [NumWords*WordW-1:0]    out_data_q, out_data_d;
  logic                         out_ok_q, out_ok_d;

  logic      accept, emit;
  char_dec_t dec;

  uuidp_char_dec u_char_dec (
    .ch_i  (s_axis_tdata_i),
    .dec_o (dec)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegReqTerm) ? {{(ApbDataW-1){1'b0}}, req_term_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_term_q <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == RegReqTerm)) begin
      req_term_q <= pwdata[0];
    end
  end

  // A new character can enter whenever the result slot is free or draining.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Per-character parse step.
  always_comb begin
    logic                         busy_e;
    logic [PosW-1:0]              pos_e, pos_inc;
    logic [NumWords-1:0][WordW-1:0] words_e;
    logic [1:0]                   widx;
    logic                         dash_pos;
    logic                         good;

    busy_e  = busy_q || s_axis_tuser_i;
    pos_e   = s_axis_tuser_i ? '0 : pos_q;
    words_e = s_axis_tuser_i ? '0 : words_q;
    pos_inc = pos_e + PosW'(1);

    if (pos_e < Word1Start) begin
      widx = 2'd0;
    end else if (pos_e < Word2Start) begin
      widx = 2'd1;
    end else if (pos_e < Word3Start) begin
      widx = 2'd2;
    end else begin
      widx = 2'd3;
    end

    dash_pos = (pos_e == DashPos0) || (pos_e == DashPos1) ||
               (pos_e == DashPos2) || (pos_e == DashPos3);

    busy_d  = busy_e;
    pos_d   = pos_e;
    words_d = words_e;
    emit    = 1'b0;
    good    = 1'b0;

    if (busy_e) begin
      if (pos_e >= UuidLen) begin
        // Terminator check after the full form.
        emit = 1'b1;
        good = dec.is_nul || !req_term_q;
      end else if (dash_pos) begin
        if (!dec.is_dash) begin
          emit = 1'b1;
        end else begin
          pos_d = pos_inc;
        end
      end else if (!dec.is_hex) begin
        emit = 1'b1;
      end else begin
        for (int i = 0; i < NumWords; i++) begin
          if (widx == 2'(i)) begin
            words_d[i] = {words_e[i][WordW-NibW-1:0], dec.nibble};
          end
        end
        pos_d = pos_inc;
        if ((pos_inc == UuidLen) && !req_term_q) begin
          emit = 1'b1;
          good = 1'b1;
        end
      end
      if (emit) begin
        busy_d = 1'b0;
      end
    end

    out_data_d = good ? words_d : '0;
    out_ok_d   = good;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pos_q   <= '0;
      words_q <= '0;
    end else if (accept) begin
      busy_q  <= busy_d;
      pos_q   <= pos_d;
      words_q <= words_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_data_q <= out_data_d;
      out_ok_q   <= out_ok_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_ok_q;

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Testbench for the UUID text parser: character streams checked against a predictor of the parse.
module tb;
  import uuidp_pkg::*;

  // One character request as the sender holds it, and one parse result as expected.
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             start;
  } char_req_t;

  typedef struct packed {
    logic                              ok;
    logic [NumWords-1:0][WordW-1:0]    words;
  } uuid_result_t;

  localparam int unsigned NumPhases     = 8;
  localparam int unsigned CharsPerPhase = 163;
  localparam logic [ApbAddrW-1:0] ReqTermAddr = {RegReqTerm, 2'b00};

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [CharW-1:0]              s_axis_tdata_i  = '0;   // [7:0] ch
  logic                          s_axis_tuser_i  = 1'b0; // [0] start_req
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [NumWords*WordW-1:0]     m_axis_tdata_o;         // [31:0] word0 .. [127:96] word3
  logic                          m_axis_tuser_o;         // [0] ok
  logic                          psel            = 1'b0;
  logic                          penable         = 1'b0;
  logic                          pwrite          = 1'b0;
  logic [ApbAddrW-1:0]           paddr           = '0;
  logic [ApbDataW-1:0]           pwdata          = '0;
  logic [ApbDataW-1:0]           prdata;
  logic                          pready;

  uuid_text_parser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Characters waiting to be offered, and parse results still owed by the block.
  char_req_t    char_queue[$];
  uuid_result_t expected_uuids[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  phase_chars;
  int unsigned  error_count = 0;

  // Predictor state: our own view of the register, the position and the words.
  logic                       model_req_term = 1'b1;
  logic [PosW-1:0]            model_pos      = '0;
  logic [NumWords-1:0][WordW-1:0] model_words = '0;
  logic                       model_busy     = 1'b0;

  // Value of a hex digit in either case, or -1 if the byte is not one.
  function automatic int hex_value(logic [CharW-1:0] c);
    if (c >= ChZero && c <= ChNine) return int'(c - ChZero);
    if (c >= ChLowA && c <= ChLowF) return int'(c - ChLowA) + 10;
    if (c >= ChUpA && c <= ChUpF) return int'(c - ChUpA) + 10;
    return -1;
  endfunction

  function automatic logic is_dash_pos(logic [PosW-1:0] p);
    return p == DashPos0 || p == DashPos1 || p == DashPos2 || p == DashPos3;
  endfunction

  // Closes the string in progress and records the result the block owes for it.
  task automatic close_string(logic good);
    uuid_result_t res;
    res.ok    = good;
    res.words = good ? model_words : '0;
    expected_uuids.push_back(res);
    model_busy = 1'b0;
  endtask

  // Follows the parse for one accepted character request.
  task automatic parse_char(logic [CharW-1:0] c, logic start);
    int nib;
    int w;
    if (start) begin
      // A start abandons whatever string was in flight, without a result.
      model_busy  = 1'b1;
      model_pos   = '0;
      model_words = '0;
    end
    if (!model_busy) return;
    if (model_pos >= UuidLen) begin
      // Whole-string mode needs a NUL here; prefix mode takes anything.
      close_string(c == ChNul || !model_req_term);
      return;
    end
    if (is_dash_pos(model_pos)) begin
      if (c != ChDash) begin
        close_string(1'b0);
        return;
      end
    end else begin
      nib = hex_value(c);
      if (nib < 0) begin
        close_string(1'b0);
        return;
      end
      if (model_pos < Word1Start) w = 0;
      else if (model_pos < Word2Start) w = 1;
      else if (model_pos < Word3Start) w = 2;
      else w = 3;
      model_words[w] = {model_words[w][WordW-NibW-1:0], NibW'(nib)};
    end
    model_pos = model_pos + 1'b1;
    // In prefix mode the last digit itself decides the string.
    if (model_pos == UuidLen && !model_req_term) close_string(1'b1);
  endtask

  // Compares the result at the master side with the oldest expectation.
  task automatic check_result();
    uuid_result_t want;
    if (expected_uuids.size() == 0) begin
      $error("result with no string pending: ok %0b, data %h", m_axis_tuser_o, m_axis_tdata_o);
      error_count++;
      return;
    end
    want = expected_uuids.pop_front();
    if (want.ok !== m_axis_tuser_o) begin
      $error("ok mismatch: expected %0b, got %0b", want.ok, m_axis_tuser_o);
      error_count++;
    end
    for (int i = 0; i < NumWords; i++) begin
      if (want.words[i] !== m_axis_tdata_o[i*WordW +: WordW]) begin
        $error("word%0d mismatch: expected %h, got %h", i, want.words[i],
               m_axis_tdata_o[i*WordW +: WordW]);
        error_count++;
      end
    end
  endtask

  // Sender: a held request stays put until the block takes it; otherwise the
  // next character is offered unless this cycle is picked as an idle one.
  always @(posedge clk_i) begin
    char_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = char_queue.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= nxt.ch;
        s_axis_tuser_i  <= nxt.start;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: back-pressure on the result stream at the rate of the phase.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: both handshakes are sampled at the edge where they complete. The
  // prediction goes first, so a result is always matched against the oldest
  // string, whatever the latency.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) parse_char(s_axis_tdata_i, s_axis_tuser_i);
      if (m_axis_tvalid_o && m_axis_tready_i) check_result();
    end
  end

  // Stimulus helpers.
  task automatic queue_char(logic [CharW-1:0] c, logic start, logic counted);
    char_queue.push_back('{ch: c, start: start});
    if (counted) phase_chars++;
  endtask

  function automatic logic [CharW-1:0] random_hex_char();
    int d;
    d = $urandom_range(15);
    if (d < 10) return ChZero + CharW'(d);
    return ($urandom_range(1) ? ChLowA : ChUpA) + CharW'(d - 10);
  endfunction

  function automatic logic [CharW-1:0] good_char(int p);
    return is_dash_pos(PosW'(p)) ? ChDash : random_hex_char();
  endfunction

  // A byte that breaks the string at position p; early NULs are made common.
  function automatic logic [CharW-1:0] bad_char(int p);
    logic [CharW-1:0] c;
    if ($urandom_range(7) == 0) return ChNul;
    do begin
      c = CharW'($urandom_range(255));
    end while (is_dash_pos(PosW'(p)) ? (c == ChDash) : (hex_value(c) >= 0));
    return c;
  endfunction

  // Bytes after the decision, which the block must drop.
  task automatic queue_trailing();
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) queue_char(CharW'($urandom_range(255)), 1'b0, 1'b0);
    end
  endtask

  // One random string. Most are well formed with random digits and case, so that
  // the terminator check and prefix mode are reached often; the rest break at a
  // random position, get cut short by a new start, or are stray bytes.
  task automatic queue_string();
    int r;
    int k;
    r = $urandom_range(99);
    if (r < 55) begin
      for (int p = 0; p < UuidLen; p++) queue_char(good_char(p), p == 0, 1'b1);
      case ($urandom_range(3))
        0, 1: queue_char(ChNul, 1'b0, 1'b1);
        2: queue_char(CharW'($urandom_range(255)), 1'b0, 1'b1);
        default: ;
      endcase
      queue_trailing();
    end else if (r < 80) begin
      k = $urandom_range(35);
      for (int p = 0; p < k; p++) queue_char(good_char(p), p == 0, 1'b1);
      queue_char(bad_char(k), k == 0, 1'b1);
      queue_trailing();
    end else if (r < 92) begin
      k = $urandom_range(1, 35);
      for (int p = 0; p < k; p++) queue_char(good_char(p), p == 0, 1'b1);
    end else begin
      repeat ($urandom_range(1, 3)) queue_char(CharW'($urandom_range(255)), 1'b0, 1'b0);
    end
  endtask

  // Short directed opening, run under whole-string mode straight after reset.
  task automatic queue_directed();
    string digits;
    digits = "0123abcd";
    queue_char("a", 1'b0, 1'b1);          // no string open: ignored
    queue_char(8'hFF, 1'b0, 1'b1);        // ignored, top byte value
    queue_char(8'hFF, 1'b1, 1'b1);        // start on a non-digit
    queue_char(ChNul, 1'b1, 1'b1);        // NUL as the very first character
    queue_char(ChDash, 1'b1, 1'b1);       // dash where a digit belongs
    queue_char("F", 1'b1, 1'b1);
    queue_char("0", 1'b0, 1'b1);
    queue_char("9", 1'b1, 1'b1);          // start while busy: restart
    queue_char("a", 1'b0, 1'b1);
    queue_char("g", 1'b0, 1'b1);          // first non-hex letter
    queue_char("A", 1'b0, 1'b1);          // after the decision: ignored
    for (int i = 0; i < digits.len(); i++) queue_char(digits[i], i == 0, 1'b1);
    queue_char("x", 1'b0, 1'b1);          // not a dash at the first dash position
  endtask

  task automatic apb_write(logic [ApbAddrW-1:0] addr, logic [ApbDataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(logic [ApbAddrW-1:0] addr, output logic [ApbDataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every character has been taken and every result has come back,
  // then lets the block settle before anything else happens.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (char_queue.size() != 0 || s_axis_tvalid_i || expected_uuids.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Main sequence. Each phase sets the register and an idling pattern, then
  // streams strings. Every phase closes with a start on a non-digit, which
  // always fails at once, so the block is idle before the next register write.
  initial begin
    logic [ApbDataW-1:0] rd_val;
    logic                req_term;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < NumPhases; ph++) begin
      req_term = (ph % 2 == 0);
      apb_write(ReqTermAddr, ApbDataW'(req_term));
      apb_read(ReqTermAddr, rd_val);
      if (rd_val !== ApbDataW'(req_term)) begin
        $error("require_terminator mismatch: expected %h, got %h", ApbDataW'(req_term), rd_val);
        error_count++;
      end
      @(negedge clk_i);
      model_req_term = req_term;
      case (ph / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      phase_chars = 0;
      if (ph == 0) queue_directed();
      while (phase_chars < CharsPerPhase) queue_string();
      queue_char(bad_char(0), 1'b1, 1'b1);
      wait_drained();
    end
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
